@@ rtl/rcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpg_pkg: shared definitions for the random cyclic permutation generator
// Command codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpg_pkg;

  // Default pool depth (largest permutation length)
  localparam int unsigned MaxLenDefault = 256;

  // Field widths
  localparam int unsigned WordW    = 31;  // random word
  localparam int unsigned CfgLenW  = 9;   // length register
  localparam int unsigned OutIdxW  = 8;   // position / successor on the bus
  localparam int unsigned InDataW  = 32;  // random word padded to bytes
  localparam int unsigned OutDataW = 16;  // position, successor

  // Length register reset value
  localparam logic [CfgLenW-1:0] CfgLenReset = CfgLenW'(256);

  // Command codes carried in tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

endpackage : rcpg_pkg

`default_nettype wire

@@ rtl/random_cyclic_permutation_gen_core.sv @@
// ----------------------------------------------------------------------------
// random_cyclic_permutation_gen_core: random single-cycle permutation builder
// Emits a random cyclic permutation of 0..len-1 as successor-table entries,
// one draw command at a time, using a bit-serial remainder unit and a pool RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Payload
//  s_axis    in   tvalid/tready        tuser = command, tdata[30:0] = random_word
//  m_axis    out  tvalid/tready        tdata[7:0] = position, [15:8] = successor,
//                                      tlast = last
//  cfg       in   cfg_we_i             cfg_wdata_i = seq_length
//
//  Draw: a transfer is followed by 31 remainder steps of the bit-serial
//  divider, 4 pool RAM read/swap steps and 1 output load; the next input is
//  accepted in the cycle after the output load. The closing entry follows
//  once the last drawn entry is taken. Start: the pool refill sweep writes
//  one RAM entry per cycle (len-1 entries); no input is taken during the sweep.
//  Reset clears control state only; pool RAM contents are rebuilt on start.
//  A stalled output holds its register; input is taken only in the idle state.
//
`default_nettype none

module random_cyclic_permutation_gen_core #(
  parameter int unsigned MAX_LEN = rcpg_pkg::MaxLenDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [rcpg_pkg::CfgLenW-1:0]  cfg_wdata_i,   // seq_length
  // input stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [rcpg_pkg::InDataW-1:0]  s_axis_tdata_i, // [30:0] random_word
  input  wire logic                          s_axis_tuser_i, // [0] command
  // output stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [rcpg_pkg::OutDataW-1:0]      m_axis_tdata_o, // [7:0] position,
                                                             // [15:8] successor
  output logic                               m_axis_tlast_o  // [0] last
);

  import rcpg_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_LEN);
  localparam int unsigned LenW = $clog2(MAX_LEN + 1);
  localparam int unsigned CmpW = (LenW > CfgLenW) ? LenW : CfgLenW;
  localparam int unsigned ExtW = (IdxW > OutIdxW) ? IdxW : OutIdxW;
  localparam int unsigned CntW = $clog2(WordW);

  // State codes
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_FILL      = 4'd1;
  localparam logic [3:0] ST_DIV       = 4'd2;
  localparam logic [3:0] ST_RD_PICK   = 4'd3;
  localparam logic [3:0] ST_RD_FRONT  = 4'd4;
  localparam logic [3:0] ST_WR_FRONT  = 4'd5;
  localparam logic [3:0] ST_WR_IDX    = 4'd6;
  localparam logic [3:0] ST_EMIT      = 4'd7;
  localparam logic [3:0] ST_EMIT_LAST = 4'd8;

  // Registers
  logic [3:0]         state_q, state_d;
  logic [CfgLenW-1:0] cfg_len_q;
  logic               running_q, running_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [LenW-1:0]    remaining_q, remaining_d;
  logic [IdxW-1:0]    pool_start_q, pool_start_d;
  logic [IdxW-1:0]    cursor_q, cursor_d;
  logic [IdxW-1:0]    fill_q, fill_d;
  logic [WordW-1:0]   div_q, div_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    picked_q, picked_d;
  logic [IdxW-1:0]    tmp_q, tmp_d;
  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;
  logic [IdxW-1:0]    out_pos_q, out_pos_d;
  logic [IdxW-1:0]    out_succ_q, out_succ_d;

  // Pool RAM
  logic [IdxW-1:0]    pool_mem [MAX_LEN];
  logic [IdxW-1:0]    mem_rdata_q;
  logic [IdxW-1:0]    mem_raddr;
  logic [IdxW-1:0]    mem_waddr;
  logic [IdxW-1:0]    mem_wdata;
  logic               mem_we;

  // Combinational helpers
  logic               in_xfer;
  logic               out_free;
  logic [CmpW-1:0]    seq_ext;
  logic [LenW-1:0]    len_c;
  logic [LenW:0]      trial;
  logic [IdxW-1:0]    pick_addr;
  logic [ExtW-1:0]    pos_ext;
  logic [ExtW-1:0]    succ_ext;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Effective length: zero reads as one, saturate at the pool depth
  assign seq_ext = CmpW'(cfg_len_q);
  always_comb begin
    priority if (seq_ext == '0) begin
      len_c = LenW'(1);
    end else if (seq_ext > CmpW'(MAX_LEN)) begin
      len_c = LenW'(MAX_LEN);
    end else begin
      len_c = LenW'(seq_ext);
    end
  end

  // One restoring remainder step
  assign trial     = {rem_q, div_q[WordW-1]};
  assign pick_addr = IdxW'(LenW'(pool_start_q) + rem_q);

  // Control and datapath next state
  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    len_d        = len_q;
    remaining_d  = remaining_q;
    pool_start_d = pool_start_q;
    cursor_d     = cursor_q;
    fill_d       = fill_q;
    div_d        = div_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    picked_d     = picked_q;
    tmp_d        = tmp_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_last_d   = out_last_q;
    out_pos_d    = out_pos_q;
    out_succ_d   = out_succ_q;
    mem_raddr    = pool_start_q;
    mem_waddr    = fill_q;
    mem_wdata    = fill_q + IdxW'(1);
    mem_we       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser_i == CMD_START) begin
            len_d        = len_c;
            remaining_d  = len_c - LenW'(1);
            pool_start_d = '0;
            cursor_d     = '0;
            fill_d       = '0;
            if (len_c == LenW'(1)) begin
              running_d = 1'b0;
              state_d   = ST_EMIT_LAST;
            end else begin
              running_d = 1'b1;
              state_d   = ST_FILL;
            end
          end else if (running_q) begin
            div_d   = s_axis_tdata_i[WordW-1:0];
            rem_d   = '0;
            cnt_d   = '0;
            state_d = ST_DIV;
          end
        end
      end

      // Refill sweep: entry i gets i+1 for i in 0..len-2
      ST_FILL: begin
        mem_we = 1'b1;
        fill_d = fill_q + IdxW'(1);
        if (LenW'(fill_q) == remaining_q - LenW'(1)) begin
          state_d = ST_IDLE;
        end
      end

      // Bit-serial word mod remaining
      ST_DIV: begin
        if (trial >= {1'b0, remaining_q}) begin
          rem_d = LenW'(trial - {1'b0, remaining_q});
        end else begin
          rem_d = LenW'(trial);
        end
        div_d = {div_q[WordW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(WordW - 1)) begin
          state_d = ST_RD_PICK;
        end
      end

      ST_RD_PICK: begin
        mem_raddr = pick_addr;
        idx_d     = pick_addr;
        state_d   = ST_RD_FRONT;
      end

      ST_RD_FRONT: begin
        mem_raddr = pool_start_q;
        picked_d  = mem_rdata_q;
        state_d   = ST_WR_FRONT;
      end

      // Swap the pick to the front of the pool
      ST_WR_FRONT: begin
        tmp_d     = mem_rdata_q;
        mem_we    = 1'b1;
        mem_waddr = pool_start_q;
        mem_wdata = picked_q;
        state_d   = ST_WR_IDX;
      end

      ST_WR_IDX: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = tmp_q;
        state_d   = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b0;
          out_pos_d    = cursor_q;
          out_succ_d   = picked_q;
          cursor_d     = picked_q;
          pool_start_d = pool_start_q + IdxW'(1);
          remaining_d  = remaining_q - LenW'(1);
          if (remaining_q == LenW'(1)) begin
            running_d = 1'b0;
            state_d   = ST_EMIT_LAST;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      // Closing entry back to zero
      ST_EMIT_LAST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_pos_d   = cursor_q;
          out_succ_d  = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_len_q    <= CfgLenReset;
      running_q    <= 1'b0;
      len_q        <= '0;
      remaining_q  <= '0;
      pool_start_q <= '0;
      cursor_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      len_q        <= len_d;
      remaining_q  <= remaining_d;
      pool_start_q <= pool_start_d;
      cursor_q     <= cursor_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        cfg_len_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fill_q     <= fill_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    picked_q   <= picked_d;
    tmp_q      <= tmp_d;
    out_last_q <= out_last_d;
    out_pos_q  <= out_pos_d;
    out_succ_q <= out_succ_d;
  end

  // Pool RAM: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= pool_mem[mem_raddr];
  end

  // Ports
  assign pos_ext  = ExtW'(out_pos_q);
  assign succ_ext = ExtW'(out_succ_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {succ_ext[OutIdxW-1:0], pos_ext[OutIdxW-1:0]};
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  a_running_has_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (remaining_q != '0))
    else $error("running with an empty pool");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < remaining_q))
    else $error("partial remainder out of range");

  a_pool_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> ((LenW+1)'(pool_start_q) + (LenW+1)'(remaining_q)
                   <= (LenW+1)'(len_q)))
    else $error("pool window beyond run length");

  a_close_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_LAST) |-> !running_q)
    else $error("closing entry while run still active");

endmodule : random_cyclic_permutation_gen_core

`default_nettype wire
